>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms; every assertion samples on clock and is
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> hw/rtl/r6m_pkg.sv
// ----------------------------------------------------------------------------
// r6m_pkg
// Shared constants of the 6D-rotation to matrix converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r6m_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 16;

   // normalized magnitudes carry their leading one at bit NORM_TOP
   localparam int NORM_W   = 30;
   localparam int NORM_TOP = NORM_W - 1;

   // entries of the queue between the front and the back part
   localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

>>> hw/rtl/r6m_req_if.sv
// ----------------------------------------------------------------------------
// r6m_req_if
// Request channel: two interleaved 3-vectors, signed Q3.12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface r6m_req_if import r6m_pkg::*; #(
   parameter int IN_WIDTH = IN_WIDTH_DEF
) ();
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] col0_x;
   logic signed [IN_WIDTH-1:0] col1_x;
   logic signed [IN_WIDTH-1:0] col0_y;
   logic signed [IN_WIDTH-1:0] col1_y;
   logic signed [IN_WIDTH-1:0] col0_z;
   logic signed [IN_WIDTH-1:0] col1_z;

   modport source (output valid, col0_x, col1_x, col0_y, col1_y, col0_z, col1_z,
                   input ready);
   modport sink   (input valid, col0_x, col1_x, col0_y, col1_y, col0_z, col1_z,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/r6m_rsp_if.sv
// ----------------------------------------------------------------------------
// r6m_rsp_if
// Response channel: 3x3 rotation matrix, row-major, signed Q1.14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface r6m_rsp_if import r6m_pkg::*; #(
   parameter int OUT_WIDTH = OUT_WIDTH_DEF
) ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] m00;
   logic signed [OUT_WIDTH-1:0] m01;
   logic signed [OUT_WIDTH-1:0] m02;
   logic signed [OUT_WIDTH-1:0] m10;
   logic signed [OUT_WIDTH-1:0] m11;
   logic signed [OUT_WIDTH-1:0] m12;
   logic signed [OUT_WIDTH-1:0] m20;
   logic signed [OUT_WIDTH-1:0] m21;
   logic signed [OUT_WIDTH-1:0] m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/r6m_unit.sv
// ----------------------------------------------------------------------------
// r6m_unit
// Pipelined unit-vector scaler: normalize, square, then one result bit per
// stage from a shift-and-subtract recurrence (rounded half away from zero).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module r6m_unit import r6m_pkg::*; #(
   parameter int MAG_W  = IN_WIDTH_DEF,
   parameter int FRAC   = OUT_WIDTH_DEF - 2,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2:0]             in_neg,
   input  logic [2:0][MAG_W-1:0]  in_mag,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [2:0][FRAC+1:0]   out_res,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NSTEP = FRAC + 1;
   localparam int LAT   = FRAC + 6;
   localparam int POS_W = $clog2(MAG_W);
   localparam int SQ_W  = 2 * NORM_W;
   localparam int N2_W  = SQ_W + 2;
   localparam int T_W   = FRAC + N2_W + 3;
   localparam int R_W   = 2 * FRAC + SQ_W + 8;
   localparam int K_W   = FRAC + 1;
   localparam int SH_W  = MAG_W + NORM_TOP;

   function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
      logic [POS_W-1:0] p;
      p = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (v[b]) p = POS_W'(b);
      end
      return p;
   endfunction

   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end

   // stage 1: leading-one position of the whole vector
   logic [MAG_W-1:0]          or_in;
   logic [2:0]                neg1_ff, neg2_ff, neg3_ff;
   logic                      zero1_ff, zero2_ff, zero3_ff;
   logic [2:0][MAG_W-1:0]     mag1_ff;
   logic [POS_W-1:0]          pos1_ff;
   logic [SIDE_W-1:0]         side1_ff, side2_ff, side3_ff;

   assign or_in = in_mag[0] | in_mag[1] | in_mag[2];

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= in_neg;
         mag1_ff  <= in_mag;
         pos1_ff  <= msb_pos(or_in);
         zero1_ff <= ~|or_in;
         side1_ff <= in_side;
      end
   end

   // stage 2: align leading one to NORM_TOP, truncating bits shifted out
   logic [2:0][NORM_W-1:0] m2_in, m2_ff;

   always_comb begin
      logic [SH_W-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         sh       = {mag1_ff[i], {NORM_TOP{1'b0}}} >> pos1_ff;
         m2_in[i] = sh[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff    <= m2_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: squares
   logic [2:0][SQ_W-1:0] sq3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= SQ_W'(m2_ff[i]) * SQ_W'(m2_ff[i]);
         end
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         side3_ff <= side2_ff;
      end
   end

   // stage 4: squared norm and recurrence seed (k = 0, odd term = -1)
   logic [N2_W-1:0]        n2_ff   [NSTEP+1];
   logic signed [R_W-1:0]  r_ff    [NSTEP+1][3];
   logic signed [T_W-1:0]  t_ff    [NSTEP+1][3];
   logic [K_W-1:0]         k_ff    [NSTEP+1][3];
   logic [2:0]             neg_ff  [NSTEP+1];
   logic                   zero_ff [NSTEP+1];
   logic [SIDE_W-1:0]      side_ff [NSTEP+1];

   logic [N2_W-1:0] n2_in;

   assign n2_in = N2_W'(sq3_ff[0]) + N2_W'(sq3_ff[1]) + N2_W'(sq3_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff[0] <= n2_in;
         for (int i = 0; i < 3; i++) begin
            r_ff[0][i] <= $signed(R_W'(sq3_ff[i]) << (2 * FRAC + 2)) - $signed(R_W'(n2_in));
            t_ff[0][i] <= -$signed(T_W'(n2_in));
            k_ff[0][i] <= '0;
         end
         neg_ff[0]  <= neg3_ff;
         zero_ff[0] <= zero3_ff;
         side_ff[0] <= side3_ff;
      end
   end

   // one result bit per stage, most significant first
   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      localparam int J = FRAC - s;

      logic signed [R_W-1:0] r_in [3];
      logic signed [T_W-1:0] t_in [3];
      logic [K_W-1:0]        k_in [3];

      always_comb begin
         logic signed [R_W-1:0] trial;
         logic                  acc;
         for (int i = 0; i < 3; i++) begin
            trial = r_ff[s][i] - (R_W'(t_ff[s][i]) <<< (J + 2))
                  - ($signed(R_W'(n2_ff[s])) <<< (2 * J + 2));
            acc     = !k_ff[s][i][FRAC] && !trial[R_W-1];
            r_in[i] = acc ? trial : r_ff[s][i];
            t_in[i] = acc ? t_ff[s][i] + ($signed(T_W'(n2_ff[s])) <<< (J + 1))
                          : t_ff[s][i];
            k_in[i] = acc ? (k_ff[s][i] | (K_W'(1) << J)) : k_ff[s][i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               r_ff[s+1][i] <= r_in[i];
               t_ff[s+1][i] <= t_in[i];
               k_ff[s+1][i] <= k_in[i];
            end
            n2_ff[s+1]   <= n2_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // output: apply sign, zero vector gives zero
   logic [2:0][FRAC+1:0] res_ff;
   logic [SIDE_W-1:0]    res_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (zero_ff[NSTEP]) begin
               res_ff[i] <= '0;
            end else if (neg_ff[NSTEP][i]) begin
               res_ff[i] <= -{1'b0, k_ff[NSTEP][i]};
            end else begin
               res_ff[i] <= {1'b0, k_ff[NSTEP][i]};
            end
         end
         res_side_ff <= side_ff[NSTEP];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_res   = res_ff;
   assign out_side  = res_side_ff;

   // last recurrence stage never exceeds one for a live beat
   logic k_top_ok;

   assign k_top_ok = !vld_ff[LAT-2]
                     || ((!k_ff[NSTEP][0][FRAC] || k_ff[NSTEP][0][FRAC-1:0] == '0)
                         && (!k_ff[NSTEP][1][FRAC] || k_ff[NSTEP][1][FRAC-1:0] == '0)
                         && (!k_ff[NSTEP][2][FRAC] || k_ff[NSTEP][2][FRAC-1:0] == '0));

   `ASSERT_CLK(a_unit_k_max, k_top_ok, "unit result above one")

endmodule

`default_nettype wire

>>> hw/rtl/r6m_front.sv
// ----------------------------------------------------------------------------
// r6m_front
// Accepts beats, forms column 0 and the orthogonalized second vector D.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r6m_front import r6m_pkg::*; #(
   parameter  int IN_WIDTH  = IN_WIDTH_DEF,
   parameter  int OUT_WIDTH = OUT_WIDTH_DEF,
   localparam int FRAC      = OUT_WIDTH - 2,
   localparam int A_W       = OUT_WIDTH,
   localparam int DM_W      = 2 * FRAC + IN_WIDTH + 2,
   localparam int MID_W     = 3 * A_W + 3 * DM_W + 3
) (
   input  logic             clock,
   input  logic             reset,
   r6m_req_if.sink          req_chan,
   output logic             mid_valid,
   input  logic             mid_ready,
   output logic [MID_W-1:0] mid_data
);

   localparam int IW   = IN_WIDTH;
   localparam int S_W  = 2 * FRAC + 2;
   localparam int C_W  = A_W + IW + 2;
   localparam int T1_W = S_W + 1 + IW;
   localparam int T2_W = C_W + A_W;
   localparam int D_W  = DM_W + 1;

   logic front_en;
   logic f1_vld_ff, f2_vld_ff, f3_vld_ff, f4_vld_ff;

   // advance unless the last stage holds a beat the queue cannot take
   assign front_en       = !f4_vld_ff || mid_ready;
   assign req_chan.ready = front_en;

   logic [2:0][IW-1:0] p_in, q_in, pmag_in;
   logic [2:0]         pneg_in;

   assign p_in = {req_chan.col0_z, req_chan.col0_y, req_chan.col0_x};
   assign q_in = {req_chan.col1_z, req_chan.col1_y, req_chan.col1_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pneg_in[i] = p_in[i][IW-1];
         pmag_in[i] = pneg_in[i] ? (~p_in[i] + 1'b1) : p_in[i];
      end
   end

   logic                 u_valid;
   logic [2:0][A_W-1:0]  u_a;
   logic [3*IW-1:0]      u_side;

   r6m_unit #(
      .MAG_W  (IW),
      .FRAC   (FRAC),
      .SIDE_W (3 * IW)
   ) u_unit_a (
      .clock     (clock),
      .reset     (reset),
      .en        (front_en),
      .in_valid  (req_chan.valid),
      .in_neg    (pneg_in),
      .in_mag    (pmag_in),
      .in_side   (q_in),
      .out_valid (u_valid),
      .out_res   (u_a),
      .out_side  (u_side)
   );

   logic [2:0][IW-1:0] uq;
   assign uq = u_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
         f4_vld_ff <= 1'b0;
      end else if (front_en) begin
         f1_vld_ff <= u_valid;
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
         f4_vld_ff <= f3_vld_ff;
      end
   end

   // F1: a*a and a*q products
   logic signed [2*A_W-1:0]  pa1_ff [3];
   logic signed [A_W+IW-1:0] pc1_ff [3];
   logic [2:0][A_W-1:0]      a1_ff, a2_ff, a3_ff, a4_ff;
   logic [2:0][IW-1:0]       q1_ff, q2_ff, q3_ff;

   always_ff @(posedge clock) begin
      if (front_en) begin
         for (int i = 0; i < 3; i++) begin
            pa1_ff[i] <= (2*A_W)'($signed(u_a[i])) * (2*A_W)'($signed(u_a[i]));
            pc1_ff[i] <= (A_W+IW)'($signed(u_a[i])) * (A_W+IW)'($signed(uq[i]));
         end
         a1_ff <= u_a;
         q1_ff <= uq;
      end
   end

   // F2: s = A.A, c = A.Q
   logic [S_W-1:0]        s2_ff;
   logic signed [C_W-1:0] c2_ff;

   always_ff @(posedge clock) begin
      if (front_en) begin
         s2_ff <= S_W'(pa1_ff[0]) + S_W'(pa1_ff[1]) + S_W'(pa1_ff[2]);
         c2_ff <= C_W'(pc1_ff[0]) + C_W'(pc1_ff[1]) + C_W'(pc1_ff[2]);
         a2_ff <= a1_ff;
         q2_ff <= q1_ff;
      end
   end

   // F3: s*q and c*a
   logic signed [T1_W-1:0] t1_ff [3];
   logic signed [T2_W-1:0] t2_ff [3];
   logic                   sz3_ff;

   always_ff @(posedge clock) begin
      if (front_en) begin
         for (int i = 0; i < 3; i++) begin
            t1_ff[i] <= T1_W'($signed({1'b0, s2_ff})) * T1_W'($signed(q2_ff[i]));
            t2_ff[i] <= T2_W'(c2_ff) * T2_W'($signed(a2_ff[i]));
         end
         sz3_ff <= (s2_ff == '0);
         a3_ff  <= a2_ff;
         q3_ff  <= q2_ff;
      end
   end

   // F4: D = s*q - c*a, or q itself when column 0 is zero
   logic [2:0]           dneg_in, dneg4_ff;
   logic [2:0][DM_W-1:0] dmag_in, dmag4_ff;

   always_comb begin
      logic signed [T2_W-1:0] full;
      logic signed [D_W-1:0]  d;
      for (int i = 0; i < 3; i++) begin
         full = T2_W'(t1_ff[i]) - t2_ff[i];
         d    = sz3_ff ? D_W'($signed(q3_ff[i])) : D_W'(full);
         dneg_in[i] = d[D_W-1];
         dmag_in[i] = dneg_in[i] ? DM_W'(-d) : DM_W'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         dneg4_ff <= dneg_in;
         dmag4_ff <= dmag_in;
         a4_ff    <= a3_ff;
      end
   end

   assign mid_valid = f4_vld_ff;
   assign mid_data  = {dneg4_ff, dmag4_ff, a4_ff};

endmodule

`default_nettype wire

>>> hw/rtl/r6m_queue.sv
// ----------------------------------------------------------------------------
// r6m_queue
// Short register queue between the front and the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module r6m_queue import r6m_pkg::*; #(
   parameter  int WIDTH = 1,
   parameter  int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   `ASSERT_CLK(a_queue_count_max, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `ASSERT_NEXT(a_queue_fill, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count missed a push")

endmodule

`default_nettype wire

>>> hw/rtl/r6m_back.sv
// ----------------------------------------------------------------------------
// r6m_back
// Scales D to column 1, forms column 2 as the cross product, drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module r6m_back import r6m_pkg::*; #(
   parameter  int IN_WIDTH  = IN_WIDTH_DEF,
   parameter  int OUT_WIDTH = OUT_WIDTH_DEF,
   localparam int FRAC      = OUT_WIDTH - 2,
   localparam int A_W       = OUT_WIDTH,
   localparam int DM_W      = 2 * FRAC + IN_WIDTH + 2,
   localparam int MID_W     = 3 * A_W + 3 * DM_W + 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_valid,
   output logic             mid_ready,
   input  logic [MID_W-1:0] mid_data,
   r6m_rsp_if.source        rsp_chan
);

   localparam int P_W = 2 * A_W;
   localparam int X_W = P_W + 1;
   localparam logic [X_W-1:0] HALF = X_W'(1) << (FRAC - 1);
   localparam logic [X_W-1:0] ONE  = X_W'(1) << FRAC;
   localparam logic signed [A_W-1:0] ONE_S = A_W'(1) << FRAC;

   function automatic logic [A_W-1:0] round_sat(input logic signed [X_W-1:0] v);
      logic [X_W-1:0] mag;
      logic [X_W-1:0] r;
      mag = v[X_W-1] ? X_W'(-v) : X_W'(v);
      r   = (mag + HALF) >> FRAC;
      if (r > ONE) r = ONE;
      return v[X_W-1] ? A_W'(-r) : A_W'(r);
   endfunction

   logic back_en;
   logic rsp_vld_ff;
   logic x1_vld_ff;

   // hold everything while a result waits at the output
   assign back_en   = !rsp_vld_ff || rsp_chan.ready;
   assign mid_ready = back_en;

   logic [2:0][A_W-1:0]  ma;
   logic [2:0][DM_W-1:0] mmag;
   logic [2:0]           mneg;

   assign ma   = mid_data[3*A_W-1:0];
   assign mmag = mid_data[3*A_W +: 3*DM_W];
   assign mneg = mid_data[MID_W-1 -: 3];

   logic                u_valid;
   logic [2:0][A_W-1:0] u_b;
   logic [3*A_W-1:0]    u_side;
   logic [2:0][A_W-1:0] ua;

   r6m_unit #(
      .MAG_W  (DM_W),
      .FRAC   (FRAC),
      .SIDE_W (3 * A_W)
   ) u_unit_b (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (mid_valid),
      .in_neg    (mneg),
      .in_mag    (mmag),
      .in_side   (ma),
      .out_valid (u_valid),
      .out_res   (u_b),
      .out_side  (u_side)
   );

   assign ua = u_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (back_en) begin
         x1_vld_ff  <= u_valid;
         rsp_vld_ff <= x1_vld_ff;
      end
   end

   // X1: six cross-product terms
   logic signed [P_W-1:0] pr1_ff [6];
   logic [2:0][A_W-1:0]   a1_ff, b1_ff, a2_ff, b2_ff;
   logic [2:0][A_W-1:0]   x2_ff;

   always_ff @(posedge clock) begin
      if (back_en) begin
         pr1_ff[0] <= P_W'($signed(ua[1])) * P_W'($signed(u_b[2]));
         pr1_ff[1] <= P_W'($signed(ua[2])) * P_W'($signed(u_b[1]));
         pr1_ff[2] <= P_W'($signed(ua[2])) * P_W'($signed(u_b[0]));
         pr1_ff[3] <= P_W'($signed(ua[0])) * P_W'($signed(u_b[2]));
         pr1_ff[4] <= P_W'($signed(ua[0])) * P_W'($signed(u_b[1]));
         pr1_ff[5] <= P_W'($signed(ua[1])) * P_W'($signed(u_b[0]));
         a1_ff     <= ua;
         b1_ff     <= u_b;
      end
   end

   // X2: difference, round, saturate into the output register
   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int i = 0; i < 3; i++) begin
            x2_ff[i] <= round_sat(X_W'(pr1_ff[2*i]) - X_W'(pr1_ff[2*i+1]));
         end
         a2_ff <= a1_ff;
         b2_ff <= b1_ff;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.m00   = a2_ff[0];
   assign rsp_chan.m01   = b2_ff[0];
   assign rsp_chan.m02   = x2_ff[0];
   assign rsp_chan.m10   = a2_ff[1];
   assign rsp_chan.m11   = b2_ff[1];
   assign rsp_chan.m12   = x2_ff[1];
   assign rsp_chan.m20   = a2_ff[2];
   assign rsp_chan.m21   = b2_ff[2];
   assign rsp_chan.m22   = x2_ff[2];

   `ASSERT_CLK(a_back_cross_range, !rsp_vld_ff || ($signed(x2_ff[2]) <= ONE_S && $signed(x2_ff[2]) >= -ONE_S), "cross product out of range")

endmodule

`default_nettype wire

>>> hw/rtl/rotation_6d_to_matrix.sv
// Throughput: one beat per cycle while neither side stalls; each unit-vector stage resolves one output bit.
// Front and back stall independently; a two-entry queue sits between them.
// Reset: synchronous, active high; clears all valid flags and empties the queue.
// No memories, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// rotation_6d_to_matrix
// Gram-Schmidt conversion of a 6D rotation code (two Q3.12 3-vectors) to a
// 3x3 rotation matrix in Q1.14.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotation_6d_to_matrix import r6m_pkg::*; #(
   parameter  int IN_WIDTH  = IN_WIDTH_DEF,
   parameter  int OUT_WIDTH = OUT_WIDTH_DEF,
   localparam int FRAC      = OUT_WIDTH - 2,
   localparam int A_W       = OUT_WIDTH,
   localparam int DM_W      = 2 * FRAC + IN_WIDTH + 2,
   localparam int MID_W     = 3 * A_W + 3 * DM_W + 3
) (
   input  logic      clock,
   input  logic      reset,
   r6m_req_if.sink   req_chan,
   r6m_rsp_if.source rsp_chan
);

   // Front -> queue: column 0 plus the sign/magnitude of D = s*Q - c*A.
   logic             fq_valid, fq_ready;
   logic [MID_W-1:0] fq_data;

   // Queue -> back.
   logic             qb_valid, qb_ready;
   logic [MID_W-1:0] qb_data;

   // Front: accept a beat, scale P to column 0, then remove the projection of Q.
   r6m_front #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .mid_valid (fq_valid),
      .mid_ready (fq_ready),
      .mid_data  (fq_data)
   );

   // Hold beats so a stalled response side does not stop intake at once.
   r6m_queue #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // Back: scale D to column 1, cross product to column 2, drive the response.
   r6m_back #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (qb_valid),
      .mid_ready (qb_ready),
      .mid_data  (qb_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotation_6d_to_matrix. A clocked driver sends
// request beats from a queue of pending vectors. A clocked monitor predicts
// each accepted beat with its own Gram-Schmidt model and compares every
// response beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench import r6m_pkg::*; ();

   localparam int IW = IN_WIDTH_DEF;
   localparam int OW = OUT_WIDTH_DEF;
   localparam int FRAC = OW - 2;
   localparam int LATENCY = 2 * FRAC + 19;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLDOFF_CYCLES = 400;

   // one pending request; a pause entry stops the sender until all is drained
   typedef struct packed {
      logic                pause;
      logic [2:0][IW-1:0]  p;
      logic [2:0][IW-1:0]  q;
   } vec_pair_type;

   typedef logic [8:0][OW-1:0] matrix_type;   // index = row*3 + column

   logic clock;
   logic reset;

   r6m_req_if #(.IN_WIDTH(IW))  req_chan ();
   r6m_rsp_if #(.OUT_WIDTH(OW)) rsp_chan ();

   rotation_6d_to_matrix u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   vec_pair_type pending_pairs[$];
   matrix_type   expected_mats[$];
   int           n_sent, n_checked, n_mismatch, n_zero_col0, n_zero_col1;
   int           idle_cnt;
   logic         holdoff_done;
   int           holdoff_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Scale a sign-magnitude vector to unit length with FRAC fraction bits.
   function automatic logic [2:0][63:0] unit_scale(logic [2:0] neg,
                                                   logic [2:0][127:0] mag);
      logic [2:0][63:0]  res;
      logic [2:0][127:0] w;
      logic [63:0]       m[3];
      logic [63:0]       top, n2, lo, hi, k, odd;
      logic [127:0]      a128, lhs, rhs;
      res = '0;
      w = mag;
      if (w == '0) return res;
      // bring the largest magnitude into [2^29, 2^30), truncating on the way down
      while ((w[0] | w[1] | w[2]) >= (128'd1 << 30)) begin
         for (int i = 0; i < 3; i++) w[i] = w[i] >> 1;
      end
      for (int i = 0; i < 3; i++) m[i] = w[i][63:0];
      top = m[0] | m[1] | m[2];
      while (top < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         top = top << 1;
      end
      n2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      for (int i = 0; i < 3; i++) begin
         a128 = 128'(m[i]) << (FRAC + 1);
         lhs = a128 * a128;
         lo = 0;
         hi = 64'd1 << FRAC;
         // largest k with (2k-1)^2 * n2 <= (2 m 2^FRAC)^2: round half away
         while (lo < hi) begin
            k = (lo + hi + 1) >> 1;
            odd = 2 * k - 1;
            rhs = 128'(odd * odd) * 128'(n2);
            if (lhs >= rhs) lo = k;
            else hi = k - 1;
         end
         res[i] = neg[i] ? -lo : lo;
      end
      return res;
   endfunction

   function automatic longint round_sat_frac(longint v);
      longint mg;
      mg = ((v < 0 ? -v : v) + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (mg > (longint'(1) << FRAC)) mg = longint'(1) << FRAC;
      return v < 0 ? -mg : mg;
   endfunction

   function automatic matrix_type gram_schmidt(vec_pair_type vp);
      longint            p[3], q[3], a[3], b[3], x[3], s, c, d;
      logic [2:0]        neg;
      logic [2:0][127:0] mag;
      logic [2:0][63:0]  u;
      matrix_type        mt;
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'($signed(vp.p[i]));
         q[i] = longint'($signed(vp.q[i]));
         neg[i] = p[i] < 0;
         mag[i] = 128'(p[i] < 0 ? -p[i] : p[i]);
      end
      u = unit_scale(neg, mag);
      s = 0;
      c = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = longint'(u[i]);
         s += a[i] * a[i];
         c += a[i] * q[i];
      end
      // remove the projection exactly; with a zero column 0 keep Q as is
      for (int i = 0; i < 3; i++) begin
         d = (s == 0) ? q[i] : s * q[i] - c * a[i];
         neg[i] = d < 0;
         mag[i] = 128'(d < 0 ? -d : d);
      end
      u = unit_scale(neg, mag);
      for (int i = 0; i < 3; i++) b[i] = longint'(u[i]);
      x[0] = round_sat_frac(a[1] * b[2] - a[2] * b[1]);
      x[1] = round_sat_frac(a[2] * b[0] - a[0] * b[2]);
      x[2] = round_sat_frac(a[0] * b[1] - a[1] * b[0]);
      for (int i = 0; i < 3; i++) begin
         mt[3 * i + 0] = a[i][OW-1:0];
         mt[3 * i + 1] = b[i][OW-1:0];
         mt[3 * i + 2] = x[i][OW-1:0];
      end
      return mt;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic vec_pair_type make_pair(int px, int py, int pz, int qx, int qy, int qz);
      vec_pair_type vp;
      vp.pause = 1'b0;
      vp.p[0] = px[IW-1:0];
      vp.p[1] = py[IW-1:0];
      vp.p[2] = pz[IW-1:0];
      vp.q[0] = qx[IW-1:0];
      vp.q[1] = qy[IW-1:0];
      vp.q[2] = qz[IW-1:0];
      return vp;
   endfunction

   // append one entry at the tail of the pending list
   task automatic enqueue_pair(vec_pair_type vp);
      pending_pairs = {pending_pairs, vp};
   endtask

   function automatic int rand_comp(int mode);
      case (mode)
         0: return int'($urandom_range(65535)) - 32768;      // full range
         1: return int'($urandom_range(32)) - 16;            // tiny magnitudes
         default: return int'($urandom_range(8192)) - 4096;  // near unit length
      endcase
   endfunction

   task automatic add_random_pairs(int count);
      int           px, py, pz, k, mode;
      vec_pair_type vp;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         px = rand_comp(mode % 3);
         py = rand_comp(mode % 3);
         pz = rand_comp(mode % 3);
         if (mode == 9) begin
            // second vector a multiple of the first: column 1 collapses
            k = int'($urandom_range(6)) - 3;
            px = px / 4;
            py = py / 4;
            pz = pz / 4;
            vp = make_pair(px, py, pz, k * px, k * py, k * pz);
         end else if (mode == 8) begin
            // nearly parallel: parallel plus a small nudge
            vp = make_pair(px / 2, py / 2, pz / 2, px / 2 + rand_comp(1), py / 2,
                           pz / 2 + rand_comp(1));
         end else begin
            vp = make_pair(px, py, pz, rand_comp(mode % 3), rand_comp(mode % 3),
                           rand_comp(mode % 3));
         end
         enqueue_pair(vp);
      end
   endtask

   task automatic add_pause();
      vec_pair_type vp;
      vp = '0;
      vp.pause = 1'b1;
      enqueue_pair(vp);
   endtask

   // ------------------------------------------------------------------------
   // Driver: advance to the next pending pair when the current beat is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.col0_x <= '0;
         req_chan.col1_x <= '0;
         req_chan.col0_y <= '0;
         req_chan.col1_y <= '0;
         req_chan.col0_z <= '0;
         req_chan.col1_z <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_pairs.size() > 0 && pending_pairs[0].pause) begin
            // hold until the block has returned everything, then drop the pause
            req_chan.valid <= 1'b0;
            if (!req_chan.valid && expected_mats.size() == 0)
               void'(pending_pairs.pop_front());
         end else if (pending_pairs.size() > 0 &&
                      ((n_sent >= 200 && n_sent < 300) || $urandom_range(99) >= 29)) begin
            req_chan.valid <= 1'b1;
            req_chan.col0_x <= pending_pairs[0].p[0];
            req_chan.col0_y <= pending_pairs[0].p[1];
            req_chan.col0_z <= pending_pairs[0].p[2];
            req_chan.col1_x <= pending_pairs[0].q[0];
            req_chan.col1_y <= pending_pairs[0].q[1];
            req_chan.col1_z <= pending_pairs[0].q[2];
            void'(pending_pairs.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off, a stall-free stretch
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         holdoff_done <= 1'b0;
         holdoff_left <= 0;
      end else if (holdoff_left > 0) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && n_sent >= 100) begin
         // starve the output long enough to back up the pipe into the input
         rsp_chan.ready <= 1'b0;
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
      end else begin
         rsp_chan.ready <= (n_sent >= 200 && n_sent < 300) || ($urandom_range(99) >= 29);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on request beats, check on response beats
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      vec_pair_type vp;
      matrix_type   got, want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            vp.pause = 1'b0;
            vp.p = {req_chan.col0_z, req_chan.col0_y, req_chan.col0_x};
            vp.q = {req_chan.col1_z, req_chan.col1_y, req_chan.col1_x};
            want = gram_schmidt(vp);
            expected_mats = {expected_mats, want};
            if (want[0] == '0 && want[3] == '0 && want[6] == '0) n_zero_col0++;
            if (want[1] == '0 && want[4] == '0 && want[7] == '0) n_zero_col1++;
            n_sent++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.m22, rsp_chan.m21, rsp_chan.m20, rsp_chan.m12, rsp_chan.m11,
                   rsp_chan.m10, rsp_chan.m02, rsp_chan.m01, rsp_chan.m00};
            if (expected_mats.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected response beat at %0t", $realtime);
            end else begin
               want = expected_mats.pop_front();
               for (int i = 0; i < 9; i++) begin
                  if (got[i] !== want[i]) begin
                     n_mismatch++;
                     if (n_mismatch <= 10)
                        $display("beat %0d m%0d%0d: expected %0d, got %0d", n_checked,
                                 i / 3, i % 3, $signed(want[i]), $signed(got[i]));
                  end
               end
            end
            n_checked++;
         end
      end
   end

   // Watchdog: count cycles with no beat on either side.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cnt <= 0;
      else if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("[rotation_6d_to_matrix] ERROR");
         $finish;
      end else
         idle_cnt <= idle_cnt + 1;
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, fill the queue, wait for the drain, report
   // ------------------------------------------------------------------------
   initial begin
      n_sent = 0;
      n_checked = 0;
      n_mismatch = 0;
      n_zero_col0 = 0;
      n_zero_col1 = 0;
      idle_cnt = 0;
      reset = 1'b1;

      // directed: zero cases, parallel cases, field extremes, axes
      enqueue_pair(make_pair(0, 0, 0, 0, 0, 0));
      enqueue_pair(make_pair(0, 0, 0, 4096, -2048, 1000));
      enqueue_pair(make_pair(0, 0, 0, -32768, 32767, -1));
      enqueue_pair(make_pair(4096, 0, 0, 0, 0, 0));
      enqueue_pair(make_pair(1000, -2000, 3000, 2000, -4000, 6000));
      enqueue_pair(make_pair(1000, -2000, 3000, -1000, 2000, -3000));
      enqueue_pair(make_pair(4096, 0, 0, 0, 4096, 0));
      enqueue_pair(make_pair(0, 4096, 0, 0, 0, 4096));
      enqueue_pair(make_pair(0, 0, 4096, 4096, 0, 0));
      enqueue_pair(make_pair(-32768, -32768, -32768, 32767, 32767, -32768));
      enqueue_pair(make_pair(32767, 32767, 32767, -32768, 0, 32767));
      enqueue_pair(make_pair(32767, -32768, 0, 32767, 32767, 32767));
      enqueue_pair(make_pair(-32768, 0, 0, -32768, 0, 0));
      enqueue_pair(make_pair(1, 0, 0, 0, 1, 0));
      enqueue_pair(make_pair(-1, -1, -1, 1, -1, 0));
      enqueue_pair(make_pair(1, 1, 1, 1, 1, 2));
      enqueue_pair(make_pair(3000, 4000, 0, -4000, 3000, 0));
      enqueue_pair(make_pair(-21846, 21845, -1, 12345, -12345, 32767));
      add_pause();
      add_random_pairs(300);
      add_pause();
      add_random_pairs(150);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_pairs.size() == 0);
      @(posedge clock);
      while (req_chan.valid || expected_mats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d request beats, %0d responses checked", n_sent, n_checked);
      $display("zero column 0 in %0d, zero column 1 in %0d; %0d mismatches",
               n_zero_col0, n_zero_col1, n_mismatch);
      if (n_mismatch == 0 && expected_mats.size() == 0) begin
         $display("[rotation_6d_to_matrix] OK");
      end else begin
         $display("[rotation_6d_to_matrix] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/r6m_pkg.sv
hw/rtl/r6m_req_if.sv
hw/rtl/r6m_rsp_if.sv
hw/rtl/r6m_unit.sv
hw/rtl/r6m_front.sv
hw/rtl/r6m_queue.sv
hw/rtl/r6m_back.sv
hw/rtl/rotation_6d_to_matrix.sv
tb/testbench.sv
